/* sv/sha256_pkg.sv */
// ----------------------------------------------------------------------------
// sha256_pkg
// shared types, constants and round functions for the sha-256 byte hasher
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned RoundCount = 64;
	localparam int unsigned TotalWidth = 61;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
	} sha_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
		logic        too_long;
	} sha_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} sha_state_t;

	// controller to datapath
	typedef struct packed {
		logic       take_byte;
		logic       pad_write;
		logic       load_work;
		logic       round_step;
		logic [5:0] round_idx;
		logic       fold;
		logic       clear;
	} sha_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       block_full;
		logic [6:0] fill_count;
	} sha_stat_t;

	localparam logic [31:0] InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PadMark    = 8'h80;
	localparam logic [6:0] LengthSlot = 7'd56;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
		ror32 = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] sig0(input logic [31:0] x);
		sig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] x);
		sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
	endfunction

endpackage

/* sv/sha256_ctrl.sv */
// ----------------------------------------------------------------------------
// sha256_ctrl
// sequencer: byte intake, padding sweep, 64 rounds, fold, digest emission
// ----------------------------------------------------------------------------
module sha256_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    in_mode,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              emit_idx,
	output sha256_pkg::sha_cmd_t    cmd,
	input  sha256_pkg::sha_stat_t   stat
);

	sha256_pkg::sha_state_t state_q, state_d;
	logic [5:0] round_q;
	logic [6:0] pad_pos_q;
	logic       finishing_q;
	logic       pad_second_q;   // current padding block is the length block
	logic [2:0] emit_q;

	logic in_fire;
	assign in_fire = in_valid && in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sha256_pkg::ST_IDLE: begin
				if (in_fire && in_mode)
					state_d = sha256_pkg::ST_PAD;
				else if (in_fire && stat.block_full)
					state_d = sha256_pkg::ST_ROUND;
			end
			sha256_pkg::ST_PAD: begin
				if (pad_pos_q == 7'd63)
					state_d = sha256_pkg::ST_ROUND;
			end
			sha256_pkg::ST_ROUND: begin
				if (round_q == 6'd63)
					state_d = sha256_pkg::ST_FOLD;
			end
			sha256_pkg::ST_FOLD: begin
				if (!finishing_q)
					state_d = sha256_pkg::ST_IDLE;
				else if (pad_second_q)
					state_d = sha256_pkg::ST_EMIT;
				else
					state_d = sha256_pkg::ST_PAD;
			end
			sha256_pkg::ST_EMIT: begin
				if (out_ready && emit_q == 3'd7)
					state_d = sha256_pkg::ST_IDLE;
			end
			default: state_d = sha256_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready       = (state_q == sha256_pkg::ST_IDLE);
		out_valid      = (state_q == sha256_pkg::ST_EMIT);
		emit_idx       = emit_q;
		cmd            = '0;
		cmd.take_byte  = in_fire && !in_mode;
		cmd.pad_write  = (state_q == sha256_pkg::ST_PAD);
		cmd.load_work  = (state_q == sha256_pkg::ST_PAD && pad_pos_q == 7'd63)
			|| (in_fire && !in_mode && stat.block_full);
		cmd.round_step = (state_q == sha256_pkg::ST_ROUND);
		cmd.round_idx  = round_q;
		cmd.fold       = (state_q == sha256_pkg::ST_FOLD);
		cmd.clear      = (state_q == sha256_pkg::ST_EMIT) && out_ready && emit_q == 3'd7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sha256_pkg::ST_IDLE;
			round_q      <= '0;
			pad_pos_q    <= '0;
			finishing_q  <= 1'b0;
			pad_second_q <= 1'b0;
			emit_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sha256_pkg::ST_ROUND)
				round_q <= round_q + 6'd1;
			if (in_fire && in_mode) begin
				finishing_q  <= 1'b1;
				pad_pos_q    <= {1'b0, stat.fill_count[5:0]};
				// 0x80 plus length fit only if at most 55 bytes pending
				pad_second_q <= (stat.fill_count < 7'd56);
			end else if (state_q == sha256_pkg::ST_PAD) begin
				pad_pos_q <= pad_pos_q + 7'd1;
			end else if (state_q == sha256_pkg::ST_FOLD && finishing_q && !pad_second_q) begin
				pad_pos_q    <= 7'd0;
				pad_second_q <= 1'b1;
			end
			if (state_q == sha256_pkg::ST_EMIT && out_ready) begin
				emit_q <= emit_q + 3'd1;
				if (emit_q == 3'd7)
					finishing_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sha256_pkg::ST_ROUND && round_q == 6'd63 |=> state_q == sha256_pkg::ST_FOLD)
		else $error("round count did not end in fold");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sha256_pkg::ST_EMIT |-> finishing_q && pad_second_q)
		else $error("emission without completed padding");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sha256_pkg::ST_IDLE |-> emit_q == 3'd0)
		else $error("emit counter not rewound");

endmodule

/* sv/sha256_dpath.sv */
// ----------------------------------------------------------------------------
// sha256_dpath
// message schedule window (also assembles the block), working registers, chain
// ----------------------------------------------------------------------------
module sha256_dpath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            data_byte,
	input  logic [2:0]            emit_idx,
	input  sha256_pkg::sha_cmd_t  cmd,
	output sha256_pkg::sha_stat_t stat,
	input  logic [6:0]            pad_pos,
	input  logic                  pad_length_blk,
	output logic [31:0]           digest_word,
	output logic                  too_long
);

	logic [6:0]  fill_q;
	logic [sha256_pkg::TotalWidth-1:0] total_q;
	logic        ovf_q;
	logic [31:0] chain_q [8];
	logic [31:0] work_q  [8];
	logic [31:0] w_q     [16];

	logic [63:0] bit_len;
	logic [7:0]  pad_byte;
	logic [5:0]  pad_addr;
	logic [2:0]  len_sel;

	// the mark is written once: only in the first padding block
	logic pad_length_blk_first;
	logic mark_done_q;
	assign pad_length_blk_first = mark_done_q;

	assign bit_len  = {total_q, 3'b000};
	assign pad_addr = pad_pos[5:0];
	assign len_sel  = pad_pos[2:0];

	// padding byte at the sweep position
	always_comb begin
		if (pad_pos[5:0] == fill_q[5:0] && !pad_length_blk_first)
			pad_byte = sha256_pkg::PadMark;
		else if (pad_pos >= sha256_pkg::LengthSlot && pad_length_blk)
			pad_byte = bit_len[8*(7 - len_sel) +: 8];
		else
			pad_byte = 8'h00;
	end

	assign stat.fill_count = fill_q;
	assign stat.block_full = (fill_q == 7'd63);

	// schedule and round terms
	logic [31:0] w_cur, w_next, t1, t2;
	assign w_cur  = w_q[0];
	assign w_next = w_q[0] + sha256_pkg::sig0(w_q[1]) + w_q[9] + sha256_pkg::sig1(w_q[14]);
	assign t1 = work_q[7] + sha256_pkg::bsig1(work_q[4])
		+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
		+ sha256_pkg::RoundK[cmd.round_idx] + w_cur;
	assign t2 = sha256_pkg::bsig0(work_q[0])
		+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));

	// bytes land big-endian straight in the schedule window
	logic [5:0] byte_addr;
	logic [7:0] byte_val;
	assign byte_addr = cmd.take_byte ? fill_q[5:0] : pad_addr;
	assign byte_val  = cmd.take_byte ? data_byte : pad_byte;

	always_ff @(posedge clk) begin
		if (cmd.take_byte || cmd.pad_write) begin
			w_q[byte_addr[5:2]][{~byte_addr[1:0], 3'b000} +: 8] <= byte_val;
		end else if (cmd.round_step) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= w_next;
		end
		if (cmd.load_work) begin
			for (int i = 0; i < 8; i++)
				work_q[i] <= chain_q[i];
		end else if (cmd.round_step) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			mark_done_q <= 1'b0;
			for (int i = 0; i < 8; i++)
				chain_q[i] <= sha256_pkg::InitH[i];
		end else begin
			if (cmd.take_byte) begin
				fill_q <= (fill_q == 7'd63) ? 7'd0 : fill_q + 7'd1;
				if (&total_q)
					ovf_q <= 1'b1;
				else
					total_q <= total_q + sha256_pkg::TotalWidth'(1);
			end
			if (cmd.pad_write && pad_pos == 7'd63)
				mark_done_q <= 1'b1;
			if (cmd.fold)
				for (int i = 0; i < 8; i++)
					chain_q[i] <= chain_q[i] + work_q[i];
			if (cmd.clear) begin
				fill_q      <= '0;
				total_q     <= '0;
				ovf_q       <= 1'b0;
				mark_done_q <= 1'b0;
				for (int i = 0; i < 8; i++)
					chain_q[i] <= sha256_pkg::InitH[i];
			end
		end
	end

	assign digest_word = chain_q[emit_idx];
	assign too_long    = ovf_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_byte |-> !cmd.pad_write && !cmd.round_step)
		else $error("byte taken during compression");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> fill_q == 7'd0 && !ovf_q)
		else $error("state not cleared after digest");
	assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> &total_q)
		else $error("overflow without saturated length");

endmodule

/* sv/sha256_byte_stream_hasher_core.sv */
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_core
// sha-256 hasher taking one message byte per request, emitting 8 digest words
// ----------------------------------------------------------------------------
// A data request (mode 0) is taken while the hasher is idle; the 64th byte
// of a block starts a compression (64 rounds through a single round unit
// and one fold into the chain words, the working registers having loaded
// on the accepting edge) during which in_ready is low and no byte is taken.
// A finish request (mode 1) sweeps the rest of the block buffer one byte a
// cycle writing the 0x80 mark, zeros and the 64-bit big-endian bit length,
// compresses, and does so twice when more than 55 bytes were pending; then
// the eight digest words leave on the output channel, word 0 first,
// last_word on word 7, too_long set on all of them if the message passed
// 2^61-1 bytes. After the eighth word is taken the hasher is back at the
// initial hash values.
module sha256_byte_stream_hasher_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sha256_pkg::sha_in_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sha256_pkg::sha_out_t out_data
);

	sha256_pkg::sha_cmd_t  cmd;
	sha256_pkg::sha_stat_t stat;
	logic [2:0]  emit_idx;
	logic [31:0] digest_word;
	logic        too_long;

	// padding sweep position lives in the controller; mirror it here
	logic [6:0] pad_pos_q;
	logic       len_blk_q;

	sha256_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_mode   (in_data.mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.emit_idx  (emit_idx),
		.cmd       (cmd),
		.stat      (stat)
	);

	// track sweep: start at fill position, restart at 0 for the length block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_pos_q <= '0;
			len_blk_q <= 1'b0;
		end else begin
			if (in_valid && in_ready && in_data.mode) begin
				pad_pos_q <= {1'b0, stat.fill_count[5:0]};
				len_blk_q <= (stat.fill_count < sha256_pkg::LengthSlot);
			end else if (cmd.pad_write) begin
				pad_pos_q <= pad_pos_q + 7'd1;
			end else if (cmd.fold && !len_blk_q) begin
				pad_pos_q <= 7'd0;
				len_blk_q <= 1'b1;
			end
		end
	end

	sha256_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_byte      (in_data.data_byte),
		.emit_idx       (emit_idx),
		.cmd            (cmd),
		.stat           (stat),
		.pad_pos        (pad_pos_q),
		.pad_length_blk (len_blk_q),
		.digest_word    (digest_word),
		.too_long       (too_long)
	);

	always_comb begin
		out_data.digest_word = digest_word;
		out_data.word_index  = emit_idx;
		out_data.last_word   = (emit_idx == 3'd7);
		out_data.too_long    = too_long;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input open during digest output");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pad_write |-> !in_ready)
		else $error("input open during padding");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha-256 byte hasher testbench
// drives directed and random messages byte by byte, ends them, checks every
// digest word against a behavioral sha-256 in a small scoreboard class
// ----------------------------------------------------------------------------

class digest_scoreboard;
	logic [31:0] chain [8];
	logic [7:0]  block [64];
	int unsigned fill;
	longint unsigned total;
	bit          overflow;
	sha256_pkg::sha_out_t pending_words [$];
	int unsigned errors;

	function new();
		errors = 0;
		clear_message();
	endfunction

	function void clear_message();
		chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		fill = 0;
		total = 0;
		overflow = 0;
	endfunction

	// force the running byte count (not called by this bench)
	function void preset_total(longint unsigned t);
		total = t;
	endfunction

	function logic [31:0] rot(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function void compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, e, a;
		for (int i = 0; i < 16; i++)
			w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + w[i-7]
				+ (rot(w[i-15], 7) ^ rot(w[i-15], 18) ^ (w[i-15] >> 3))
				+ (rot(w[i-2], 17) ^ rot(w[i-2], 19) ^ (w[i-2] >> 10));
		v = chain;
		for (int i = 0; i < 64; i++) begin
			e = v[4];
			a = v[0];
			t1 = v[7] + (rot(e, 6) ^ rot(e, 11) ^ rot(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
				+ sha256_pkg::RoundK[i] + w[i];
			t2 = (rot(a, 2) ^ rot(a, 13) ^ rot(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = e; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = a; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] += v[i];
	endfunction

	function void note_request(sha256_pkg::sha_in_t req);
		longint unsigned limit;
		logic [63:0] bits;
		sha256_pkg::sha_out_t word;
		limit = (64'd1 << 61) - 1;
		if (!req.mode) begin
			if (total >= limit) begin
				total = limit;
				overflow = 1;
			end else
				total++;
			block[fill] = req.data_byte;
			fill++;
			if (fill == 64) begin
				compress_block();
				fill = 0;
			end
			return;
		end
		block[fill] = sha256_pkg::PadMark;
		fill++;
		if (fill > 56) begin
			while (fill < 64) block[fill++] = 8'h00;
			compress_block();
			fill = 0;
		end
		while (fill < 56) block[fill++] = 8'h00;
		bits = total << 3;
		for (int k = 0; k < 8; k++)
			block[56+k] = bits[63-8*k -: 8];
		compress_block();
		for (int k = 0; k < 8; k++) begin
			word.digest_word = chain[k];
			word.word_index = k[2:0];
			word.last_word = (k == 7);
			word.too_long = overflow;
			pending_words.push_back(word);
		end
		clear_message();
	endfunction

	function void check_word(sha256_pkg::sha_out_t got);
		sha256_pkg::sha_out_t exp;
		if (pending_words.size() == 0) begin
			$display("%0t: unexpected digest word, expected none, actual %h", $time, got);
			errors++;
			return;
		end
		exp = pending_words.pop_front();
		if (got.digest_word !== exp.digest_word) begin
			$display("%0t: digest_word expected %h actual %h", $time, exp.digest_word,
				got.digest_word);
			errors++;
		end
		if (got.word_index !== exp.word_index) begin
			$display("%0t: word_index expected %0d actual %0d", $time, exp.word_index,
				got.word_index);
			errors++;
		end
		if (got.last_word !== exp.last_word) begin
			$display("%0t: last_word expected %b actual %b", $time, exp.last_word, got.last_word);
			errors++;
		end
		if (got.too_long !== exp.too_long) begin
			$display("%0t: too_long expected %b actual %b", $time, exp.too_long, got.too_long);
			errors++;
		end
	endfunction
endclass

module testbench;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 in_valid = 0;
	logic                 in_ready;
	sha256_pkg::sha_in_t  in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 0;
	sha256_pkg::sha_out_t out_data;

	digest_scoreboard board;
	int unsigned burst_left = 0;
	int unsigned stall_mode = 0;
	int unsigned rx_phase = 0;

	always #6 clk = ~clk;

	sha256_byte_stream_hasher_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// sample both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			board.note_request(in_data);
		if (arst_n && out_valid && out_ready)
			board.check_word(out_data);
	end

	// receiver stalls on its own pattern: open, periodic, random, heavy
	always @(negedge clk) begin
		rx_phase++;
		if (rx_phase % 97 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= (rx_phase % 3 != 0);
			2: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	// one request held until taken, with bursts and random gaps between them;
	// valid stays up between requests of a burst and drops only for a gap
	task automatic send_request(input logic mode, input logic [7:0] value);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_data <= '{mode: mode, data_byte: value};
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_message(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			send_request(1'b0, 8'($urandom_range(0, 255)));
		send_request(1'b1, 8'($urandom_range(0, 255)));
	endtask

	task automatic drain_results();
		in_valid <= 0;
		burst_left = 0;
		while (board.pending_words.size() != 0) @(negedge clk);
	endtask

	initial begin
		int unsigned sent;
		int unsigned len;
		board = new();
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: empty message, single extreme bytes, and the padding boundaries
		send_message(0);
		send_request(1'b0, 8'h00);
		send_request(1'b1, 8'hff);
		send_request(1'b0, 8'hff);
		send_request(1'b1, 8'h00);
		send_message(55);
		send_message(56);
		drain_results();
		send_message(63);
		send_message(64);
		drain_results();

		// random messages, mostly short, each finished so that it brings a digest
		sent = 0;
		while (sent < 223) begin
			case ($urandom_range(0, 9))
				0: len = $urandom_range(52, 70);
				1: len = $urandom_range(100, 140);
				default: len = $urandom_range(0, 20);
			endcase
			send_message(len);
			sent += len + 1;
		end
		drain_results();
		repeat (300) @(negedge clk);
		if (board.errors == 0)
			$display("sha256_byte_stream_hasher_core regression: pass");
		else
			$display("sha256_byte_stream_hasher_core regression: fail");
		$finish;
	end

	initial begin
		#5ms;
		$display("sha256_byte_stream_hasher_core regression: fail");
		$finish;
	end

endmodule
